// ----- hw/rtl/rx_descriptor_ring_consumer_assert.svh -----
// Assertion helpers for the receive ring modules; only rdrc_back includes them.
`ifndef RX_DESCRIPTOR_RING_CONSUMER_ASSERT_SVH
`define RX_DESCRIPTOR_RING_CONSUMER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RDRC_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define RDRC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

// ----- hw/rtl/rdrc_pkg.sv -----
package rdrc_pkg;

    localparam int RING_SLOTS_DEF  = 16;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam int LEN_W      = 12;
    localparam int CNT_W      = 32;
    localparam int SLOT_OUT_W = 8;
    localparam int STAT_W     = 3;

    localparam logic [LEN_W-1:0] CRC_BYTES = 12'd4;

    localparam logic CMD_INIT    = 1'b0;
    localparam logic CMD_EXAMINE = 1'b1;

    localparam logic [STAT_W-1:0] ST_HANDLED  = 3'd0;
    localparam logic [STAT_W-1:0] ST_DONE     = 3'd1;
    localparam logic [STAT_W-1:0] ST_NOT_INIT = 3'd2;
    localparam logic [STAT_W-1:0] ST_BOGUS    = 3'd3;
    localparam logic [STAT_W-1:0] ST_NO_START = 3'd4;
    localparam logic [STAT_W-1:0] ST_NO_END   = 3'd5;
    localparam logic [STAT_W-1:0] ST_FATAL    = 3'd6;

    typedef struct packed {
        logic             cmd;
        logic             first_of_batch;
        logic             drop_all;
        logic             chip_owned;
        logic             start_of_packet;
        logic             end_of_packet;
        logic             error_summary;
        logic             framing_error;
        logic             overflow_error;
        logic             crc_error;
        logic             buffer_error;
        logic [LEN_W-1:0] message_count;
    } t_rx_in;

    typedef struct packed {
        logic [STAT_W-1:0]     status;
        logic                  deliver;
        logic [LEN_W-1:0]      packet_length;
        logic [SLOT_OUT_W-1:0] slot_index;
        logic [CNT_W-1:0]      packets_received;
        logic [CNT_W-1:0]      crc_error_count;
        logic [CNT_W-1:0]      frame_error_count;
        logic [CNT_W-1:0]      overrun_error_count;
    } t_rx_out;

    // Request after classification; the status assumes the ring is ready.
    typedef struct packed {
        logic              is_init;
        logic [STAT_W-1:0] kind;
        logic              deliver;
        logic [LEN_W-1:0]  length;
        logic              inc_crc;
        logic              inc_frame;
        logic              inc_overrun;
    } t_rx_cls;

endpackage

// ----- hw/rtl/rdrc_front.sv -----
module rdrc_front import rdrc_pkg::*; (
    input  t_rx_in  i_item,
    output t_rx_cls o_cls
);

    logic toss;
    logic fatal;

    always_comb begin
        o_cls = '0;
        toss  = i_item.drop_all;
        fatal = 1'b0;
        if (i_item.cmd == CMD_INIT) begin
            o_cls.is_init = 1'b1;
            o_cls.kind    = ST_HANDLED;
        end else if (i_item.chip_owned) begin
            o_cls.kind = i_item.first_of_batch ? ST_BOGUS : ST_DONE;
        end else if (!i_item.start_of_packet) begin
            o_cls.kind = ST_NO_START;
        end else if (!i_item.end_of_packet && !i_item.error_summary) begin
            o_cls.kind = ST_NO_END;
        end else begin
            if (!i_item.end_of_packet) begin
                // A chained packet cut short: only overrun is counted, and a buffer error is fatal.
                toss              = 1'b1;
                o_cls.inc_overrun = i_item.overflow_error;
                fatal             = i_item.buffer_error;
            end else if (i_item.error_summary) begin
                toss            = 1'b1;
                o_cls.inc_frame = i_item.framing_error;
                o_cls.inc_crc   = i_item.crc_error;
            end
            if (fatal) begin
                o_cls.kind = ST_FATAL;
            end else begin
                o_cls.kind    = ST_HANDLED;
                o_cls.deliver = !toss;
                o_cls.length  = (i_item.message_count >= CRC_BYTES) ?
                                (i_item.message_count - CRC_BYTES) : '0;
            end
        end
    end

endmodule

// ----- hw/rtl/rdrc_queue.sv -----
module rdrc_queue import rdrc_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_rx_cls i_data,
    output logic    o_full,
    output logic    o_valid,
    output t_rx_cls o_data,
    input  logic    i_pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W_Q = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0]   LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W_Q-1:0] FULL_CNT = CNT_W_Q'(DEPTH);

    t_rx_cls r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W_Q-1:0] r_count;
    logic [CNT_W_Q-1:0] n_count;

    assign o_full  = (r_count == FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !(i_pop && o_valid)) begin
            n_count = r_count + CNT_W_Q'(1);
        end else if (!i_push && i_pop && o_valid) begin
            n_count = r_count - CNT_W_Q'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (i_pop && o_valid) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PTR_W'(1);
            end
        end
    end

endmodule

// ----- hw/rtl/rdrc_back.sv -----
`include "rx_descriptor_ring_consumer_assert.svh"

module rdrc_back import rdrc_pkg::*; #(
    parameter int RING_SLOTS = RING_SLOTS_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_q_valid,
    input  t_rx_cls i_q_data,
    output logic    o_pop,
    output logic    o_out_valid,
    output t_rx_out o_out_data,
    input  logic    i_out_stall
);

    localparam int SLOT_W = $clog2(RING_SLOTS);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(RING_SLOTS - 1);

    logic              r_ready;
    logic              n_ready;
    logic [SLOT_W-1:0] r_slot;
    logic [SLOT_W-1:0] n_slot;
    logic [CNT_W-1:0]  r_rx;
    logic [CNT_W-1:0]  n_rx;
    logic [CNT_W-1:0]  r_crc;
    logic [CNT_W-1:0]  n_crc;
    logic [CNT_W-1:0]  r_frame;
    logic [CNT_W-1:0]  n_frame;
    logic [CNT_W-1:0]  r_overrun;
    logic [CNT_W-1:0]  n_overrun;
    logic              r_out_valid;
    t_rx_out           r_out;
    t_rx_out           n_out;
    logic              load;

    // The output register takes a new request whenever it is empty or being drained.
    assign load        = i_q_valid && (!r_out_valid || !i_out_stall);
    assign o_pop       = load;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        n_ready   = r_ready;
        n_slot    = r_slot;
        n_rx      = r_rx;
        n_crc     = r_crc;
        n_frame   = r_frame;
        n_overrun = r_overrun;
        n_out     = '0;
        if (i_q_data.is_init) begin
            n_ready          = 1'b1;
            n_slot           = '0;
            n_out.status     = ST_HANDLED;
        end else if (!r_ready) begin
            n_out.status     = ST_NOT_INIT;
            n_out.slot_index = SLOT_OUT_W'(r_slot);
        end else begin
            n_out.status        = i_q_data.kind;
            n_out.deliver       = i_q_data.deliver;
            n_out.packet_length = i_q_data.length;
            n_out.slot_index    = SLOT_OUT_W'(r_slot);
            n_crc               = r_crc + CNT_W'(i_q_data.inc_crc);
            n_frame             = r_frame + CNT_W'(i_q_data.inc_frame);
            n_overrun           = r_overrun + CNT_W'(i_q_data.inc_overrun);
            if (i_q_data.kind == ST_HANDLED) begin
                n_rx   = r_rx + CNT_W'(1);
                n_slot = (r_slot == LAST_SLOT) ? '0 : r_slot + SLOT_W'(1);
            end
        end
        n_out.packets_received    = n_rx;
        n_out.crc_error_count     = n_crc;
        n_out.frame_error_count   = n_frame;
        n_out.overrun_error_count = n_overrun;
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready     <= 1'b0;
            r_slot      <= '0;
            r_rx        <= '0;
            r_crc       <= '0;
            r_frame     <= '0;
            r_overrun   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_ready     <= n_ready;
                r_slot      <= n_slot;
                r_rx        <= n_rx;
                r_crc       <= n_crc;
                r_frame     <= n_frame;
                r_overrun   <= n_overrun;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    `RDRC_ASSERT_SAME(a_deliver_handled, i_clk, i_rst_n,
                      r_out_valid && r_out.deliver, r_out.status == ST_HANDLED)
    `RDRC_ASSERT_SAME(a_len_zero, i_clk, i_rst_n,
                      r_out_valid && (r_out.status != ST_HANDLED), r_out.packet_length == '0)
    `RDRC_ASSERT_NEXT(a_slot_step, i_clk, i_rst_n,
                      load && r_ready && !i_q_data.is_init && (i_q_data.kind == ST_HANDLED),
                      r_slot != $past(r_slot))
    `RDRC_ASSERT_NEXT(a_init_slot, i_clk, i_rst_n,
                      load && i_q_data.is_init, r_ready && (r_slot == '0))

endmodule

// ----- hw/rtl/rx_descriptor_ring_consumer.sv -----
// A request accepted on the input is written into the queue, then into the output register that drives o_out_valid.
// Throughput: one request per cycle; the queue (two entries by default) between classifier and the
// counter stage stalls the input only when it is full behind a stalled output register.
// Reset (i_rst_n low, synchronous) clears ring ready, slot index, all four counters,
// the queue and the output valid; the stored payloads are not cleared.
module rx_descriptor_ring_consumer import rdrc_pkg::*; #(
    parameter int RING_SLOTS  = RING_SLOTS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    input  t_rx_in  i_in_data,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    output t_rx_out o_out_data
);

    t_rx_cls cls;
    t_rx_cls q_data;
    logic    q_full;
    logic    q_valid;
    logic    q_pop;
    logic    push;

    assign o_in_stall = q_full;
    assign push       = i_in_valid && !q_full;

    rdrc_front u_front (
        .i_item (i_in_data),
        .o_cls  (cls)
    );

    rdrc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (cls),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_data),
        .i_pop   (q_pop)
    );

    rdrc_back #(
        .RING_SLOTS (RING_SLOTS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_data    (q_data),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
    import rdrc_pkg::*;

    localparam int SLOTS = RING_SLOTS_DEF;

    typedef struct {
        t_rx_in req;
        bit     wait_idle;
    } t_pending_req;

    logic    i_clk       = 1'b0;
    logic    i_rst_n     = 1'b0;
    logic    i_in_valid  = 1'b0;
    logic    o_in_stall;
    t_rx_in  i_in_data   = '0;
    logic    o_out_valid;
    logic    i_out_stall = 1'b0;
    t_rx_out o_out_data;

    rx_descriptor_ring_consumer #(
        .RING_SLOTS(SLOTS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data)
    );

    // Shadow of the ring state.
    logic        ring_ok       = 1'b0;
    logic [7:0]  slot_now      = '0;
    logic [31:0] rx_total      = '0;
    logic [31:0] crc_total     = '0;
    logic [31:0] frame_total   = '0;
    logic [31:0] overrun_total = '0;

    t_pending_req descriptor_q[$];
    t_rx_out      ring_results_q[$];

    int mismatch_count = 0;
    int burst_left     = 8;
    int gap_left       = 0;
    int stall_mode     = 0;
    int stall_run      = 0;
    int cycle_count    = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        if (mismatch_count < 50) begin
            $display("%0t ns: %s", $time, msg);
        end
        mismatch_count++;
    endtask

    function automatic t_rx_out classify_descriptor(input t_rx_in d);
        t_rx_out r;
        logic    toss;
        logic    fatal;
        r = '0;
        r.status = ST_HANDLED;
        r.slot_index = slot_now;
        if (d.cmd == CMD_INIT) begin
            ring_ok = 1'b1;
            slot_now = '0;
            r.slot_index = '0;
        end else if (!ring_ok) begin
            r.status = ST_NOT_INIT;
        end else if (d.chip_owned) begin
            r.status = d.first_of_batch ? ST_BOGUS : ST_DONE;
        end else if (!d.start_of_packet) begin
            r.status = ST_NO_START;
        end else if (!d.end_of_packet && !d.error_summary) begin
            r.status = ST_NO_END;
        end else begin
            toss = d.drop_all;
            fatal = 1'b0;
            // Without an end flag the error summary is set, so the packet spilled.
            if (!d.end_of_packet) begin
                toss = 1'b1;
                if (d.overflow_error) overrun_total++;
                if (d.buffer_error) fatal = 1'b1;
            end else if (d.error_summary) begin
                toss = 1'b1;
                if (d.framing_error) frame_total++;
                if (d.crc_error) crc_total++;
            end
            if (fatal) begin
                r.status = ST_FATAL;
            end else begin
                rx_total++;
                r.packet_length = (d.message_count >= CRC_BYTES) ?
                                  d.message_count - CRC_BYTES : '0;
                r.deliver = !toss;
                slot_now = (slot_now == SLOTS - 1) ? 8'd0 : slot_now + 8'd1;
            end
        end
        r.packets_received = rx_total;
        r.crc_error_count = crc_total;
        r.frame_error_count = frame_total;
        r.overrun_error_count = overrun_total;
        return r;
    endfunction

    function automatic t_rx_in make_desc(input logic cmd, input logic first, input logic drop,
                                         input logic owned, input logic sop, input logic eop,
                                         input logic err, input logic fram, input logic ovfl,
                                         input logic crc, input logic buferr,
                                         input logic [LEN_W-1:0] count);
        t_rx_in d;
        d.cmd = cmd;
        d.first_of_batch = first;
        d.drop_all = drop;
        d.chip_owned = owned;
        d.start_of_packet = sop;
        d.end_of_packet = eop;
        d.error_summary = err;
        d.framing_error = fram;
        d.overflow_error = ovfl;
        d.crc_error = crc;
        d.buffer_error = buferr;
        d.message_count = count;
        return d;
    endfunction

    function automatic t_rx_in random_descriptor();
        t_rx_in d;
        int     roll;
        d = t_rx_in'($urandom);
        d.cmd = CMD_EXAMINE;
        roll = $urandom_range(0, 99);
        if (roll < 3) begin
            d.cmd = CMD_INIT;
        end else if (roll < 65) begin
            // Complete packet in one buffer, occasionally with errors or dropped.
            d.chip_owned = 1'b0;
            d.start_of_packet = 1'b1;
            d.end_of_packet = 1'b1;
            d.error_summary = ($urandom_range(0, 4) == 0);
            d.drop_all = ($urandom_range(0, 7) == 0);
        end else if (roll < 80) begin
            d.chip_owned = 1'b0;
            d.start_of_packet = 1'b1;
            d.end_of_packet = 1'b0;
        end
        if ($urandom_range(0, 3) == 0) begin
            d.message_count = LEN_W'($urandom_range(0, 8));
        end
        return d;
    endfunction

    task automatic add_request(input t_rx_in d, input bit wait_idle);
        t_pending_req p;
        p.req = d;
        p.wait_idle = wait_idle;
        descriptor_q.push_back(p);
    endtask

    always @(posedge i_clk) begin : drive_proc
        logic   nxt_valid;
        t_rx_in nxt_data;
        nxt_valid = i_in_valid;
        nxt_data = i_in_data;
        if (!i_rst_n) begin
            nxt_valid = 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                ring_results_q.push_back(classify_descriptor(i_in_data));
                void'(descriptor_q.pop_front());
                nxt_valid = 1'b0;
                if (burst_left > 0) burst_left--;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 40);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
            if (!nxt_valid && descriptor_q.size() > 0) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (!(descriptor_q[0].wait_idle && ring_results_q.size() != 0)) begin
                    nxt_valid = 1'b1;
                    nxt_data = descriptor_q[0].req;
                end
            end
        end
        i_in_valid <= nxt_valid;
        i_in_data <= nxt_data;
    end

    always @(posedge i_clk) begin : check_proc
        t_rx_out want;
        logic    nxt_stall;
        cycle_count++;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (ring_results_q.size() == 0) begin
                report_mismatch("result arrived with no request outstanding");
            end else begin
                want = ring_results_q.pop_front();
                if (o_out_data.status !== want.status)
                    report_mismatch($sformatf("status: got %0d, expected %0d",
                                              o_out_data.status, want.status));
                if (o_out_data.deliver !== want.deliver)
                    report_mismatch($sformatf("deliver: got %0d, expected %0d",
                                              o_out_data.deliver, want.deliver));
                if (o_out_data.packet_length !== want.packet_length)
                    report_mismatch($sformatf("packet_length: got %0d, expected %0d",
                                              o_out_data.packet_length, want.packet_length));
                if (o_out_data.slot_index !== want.slot_index)
                    report_mismatch($sformatf("slot_index: got %0d, expected %0d",
                                              o_out_data.slot_index, want.slot_index));
                if (o_out_data.packets_received !== want.packets_received)
                    report_mismatch($sformatf("packets_received: got %0d, expected %0d",
                                              o_out_data.packets_received,
                                              want.packets_received));
                if (o_out_data.crc_error_count !== want.crc_error_count)
                    report_mismatch($sformatf("crc_error_count: got %0d, expected %0d",
                                              o_out_data.crc_error_count,
                                              want.crc_error_count));
                if (o_out_data.frame_error_count !== want.frame_error_count)
                    report_mismatch($sformatf("frame_error_count: got %0d, expected %0d",
                                              o_out_data.frame_error_count,
                                              want.frame_error_count));
                if (o_out_data.overrun_error_count !== want.overrun_error_count)
                    report_mismatch($sformatf("overrun_error_count: got %0d, expected %0d",
                                              o_out_data.overrun_error_count,
                                              want.overrun_error_count));
            end
        end
        // The receiver switches between free-running, random, heavy and periodic stalls.
        if (stall_run == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_run = $urandom_range(16, 160);
        end else begin
            stall_run--;
        end
        case (stall_mode)
            0: nxt_stall = 1'b0;
            1: nxt_stall = 1'($urandom_range(0, 1));
            2: nxt_stall = ($urandom_range(0, 4) != 0);
            default: nxt_stall = ((cycle_count % 16) < 5);
        endcase
        i_out_stall <= nxt_stall;
    end

    initial begin : stimulus_proc
        int n;
        // Examines before the ring is initialized.
        add_request(make_desc(CMD_EXAMINE, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1,
                              1'b1, 1'b1, 1'b1, 1'b1, 12'hFFF), 1'b0);
        add_request(make_desc(CMD_EXAMINE, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0,
                              1'b0, 1'b0, 1'b0, 1'b0, 12'd64), 1'b0);
        add_request(make_desc(CMD_INIT, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                              1'b0, 1'b0, 1'b0, 1'b0, 12'd0), 1'b0);
        // Ownership and boundary flags.
        add_request(make_desc(CMD_EXAMINE, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0,
                              1'b0, 1'b0, 1'b0, 1'b0, 12'd100), 1'b0);
        add_request(make_desc(CMD_EXAMINE, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0,
                              1'b0, 1'b0, 1'b0, 1'b0, 12'd100), 1'b0);
        add_request(make_desc(CMD_EXAMINE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0,
                              1'b0, 1'b0, 1'b0, 1'b0, 12'd100), 1'b0);
        add_request(make_desc(CMD_EXAMINE, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0,
                              1'b1, 1'b1, 1'b1, 1'b1, 12'd100), 1'b0);
        // Spilled packet, fatal and non-fatal.
        add_request(make_desc(CMD_EXAMINE, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1,
                              1'b0, 1'b1, 1'b0, 1'b1, 12'd200), 1'b0);
        add_request(make_desc(CMD_EXAMINE, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1,
                              1'b1, 1'b1, 1'b1, 1'b0, 12'd200), 1'b0);
        add_request(make_desc(CMD_EXAMINE, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1,
                              1'b0, 1'b0, 1'b0, 1'b0, 12'd3), 1'b0);
        // Length saturation around the CRC bytes.
        add_request(make_desc(CMD_EXAMINE, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0,
                              1'b0, 1'b0, 1'b0, 1'b0, 12'd0), 1'b0);
        add_request(make_desc(CMD_EXAMINE, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0,
                              1'b0, 1'b0, 1'b0, 1'b0, 12'd3), 1'b0);
        add_request(make_desc(CMD_EXAMINE, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0,
                              1'b0, 1'b0, 1'b0, 1'b0, 12'd4), 1'b0);
        add_request(make_desc(CMD_EXAMINE, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0,
                              1'b0, 1'b0, 1'b0, 1'b0, 12'd5), 1'b0);
        add_request(make_desc(CMD_EXAMINE, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0,
                              1'b0, 1'b0, 1'b0, 1'b0, 12'hFFF), 1'b0);
        // Errors at end of packet; flags without the summary bit are ignored.
        add_request(make_desc(CMD_EXAMINE, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1,
                              1'b1, 1'b0, 1'b1, 1'b0, 12'd60), 1'b0);
        add_request(make_desc(CMD_EXAMINE, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1,
                              1'b0, 1'b0, 1'b0, 1'b0, 12'd60), 1'b0);
        add_request(make_desc(CMD_EXAMINE, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0,
                              1'b1, 1'b1, 1'b1, 1'b1, 12'd60), 1'b0);
        add_request(make_desc(CMD_EXAMINE, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0,
                              1'b0, 1'b0, 1'b0, 1'b0, 12'd1514), 1'b0);
        add_request(make_desc(CMD_EXAMINE, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1,
                              1'b1, 1'b1, 1'b1, 1'b1, 12'hAAA), 1'b0);
        // Re-initialize in the middle of the ring once everything has drained.
        add_request(make_desc(CMD_INIT, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1,
                              1'b1, 1'b1, 1'b1, 1'b1, 12'h555), 1'b1);
        add_request(make_desc(CMD_EXAMINE, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0,
                              1'b0, 1'b0, 1'b0, 1'b0, 12'd64), 1'b0);

        for (n = 0; n < 1100; n++) begin
            add_request(random_descriptor(), (n % 250) == 249);
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (descriptor_q.size() != 0 || ring_results_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (5) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
